FILE: rtl/plr_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// plr_pkg
// Shared types and constants of the polyphase resampler.
// ----------------------------------------------------------------------------
package plr_pkg;

  localparam int SW         = 16;
  localparam int MAX_TAPS   = 64;
  localparam int TAP_W      = 6;
  localparam int TCNT_W     = 7;
  localparam int MAX_PHASES = 256;
  localparam int PH_W       = 8;
  localparam int CW         = 32;
  localparam int ACC_W      = 38;
  localparam int WS_W       = 22;
  localparam int OFF_W      = 7;
  localparam int UP_W       = 9;
  localparam int DOWN_W     = 11;
  localparam int TSUM_W     = 12;
  localparam int DIV_NW     = 44;
  localparam int DIV_DW     = 24;
  localparam int DIV_IW     = 6;
  localparam int MAX_OUT    = 64;
  localparam int CFG_IDX_W  = 4;
  localparam int CFG_DATA_W = 16;

  localparam logic [CFG_IDX_W-1:0] CFG_UP   = 4'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_DOWN = 4'd1;

  typedef enum logic [1:0] {
    FUNC_SAMPLE = 2'd0,
    FUNC_WEIGHT = 2'd1,
    FUNC_SHAPE  = 2'd2,
    FUNC_FLUSH  = 2'd3
  } func_e;

  typedef enum logic [3:0] {
    S_IDLE,
    S_TGT,
    S_LOOK,
    S_CHECK,
    S_TAP,
    S_DRAIN,
    S_DIVO,
    S_ADV,
    S_ADVW,
    S_EMIT
  } state_e;

  typedef struct packed {
    logic              start;
    logic [DIV_NW-1:0] num;
    logic [DIV_DW-1:0] den;
    logic [DIV_IW-1:0] iters;
  } div_req_t;

  typedef struct packed {
    logic              done;
    logic [DIV_NW-1:0] quo;
    logic [DIV_DW-1:0] rem;
  } div_rsp_t;

endpackage
`default_nettype wire

FILE: rtl/plr_if.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// plr channel interfaces
// Valid/ready channels for input items, results and register writes.
// ----------------------------------------------------------------------------
interface plr_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  func;
  logic [15:0] in_sample;
  logic [7:0]  phase_sel;
  logic [5:0]  tap_sel;
  logic [15:0] weight_value;
  logic [6:0]  left_offset;
  logic [6:0]  tap_total;
  modport source (output valid, func, in_sample, phase_sel, tap_sel, weight_value,
                  left_offset, tap_total, input ready);
  modport sink (input valid, func, in_sample, phase_sel, tap_sel, weight_value,
                left_offset, tap_total, output ready);
endinterface

interface plr_out_if;
  logic        valid;
  logic        ready;
  logic [15:0] out_sample;
  logic        last_of_run;
  modport source (output valid, out_sample, last_of_run, input ready);
  modport sink (input valid, out_sample, last_of_run, output ready);
endinterface

interface plr_cfg_if;
  logic        valid;
  logic        ready;
  logic [3:0]  index;
  logic [15:0] data;
  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface
`default_nettype wire

FILE: rtl/polyphase_lanczos_resampler.sv
`timescale 1ns / 1ps
`default_nettype none
// loads leave the block idle; a pass-through sample goes through a pending register, then the output register
// each output: tap walk, divide by the weight sum if positive, then a phase-step divide
// a non-pass flush adds a divide for its target count; the shared divider sets the rate
// one item in flight at a time; results leave through a one-entry output register
// reset: counters zero, both factors 1; sample, weight and phase memories are not cleared
// ----------------------------------------------------------------------------
// polyphase_lanczos_resampler
// Rational-ratio polyphase resampler with loadable kernel and shared divider.
// ----------------------------------------------------------------------------
module polyphase_lanczos_resampler
  import plr_pkg::*;
#(
  parameter int RING_DEPTH = 128
) (
  input wire logic clk_i,
  input wire logic rst_ni,
  plr_in_if.sink   sample_in,
  plr_cfg_if.sink  cfg_wr,
  plr_out_if.source result_out
);

  localparam int RW = $clog2(RING_DEPTH);
  localparam int JW = CW + 2;

  state_e state_q, state_d;

  logic [UP_W-1:0]   up_q, up_d;
  logic [DOWN_W-1:0] down_q, down_d;
  func_e             func_q, func_d;
  logic [CW-1:0]     seen_q, seen_d;
  logic [CW-1:0]     idx_q, idx_d;
  logic [CW-1:0]     center_q, center_d;
  logic [PH_W-1:0]   phase_q, phase_d;
  logic [DIV_NW-1:0] target_q, target_d;
  logic [TCNT_W-1:0] cnt_q, cnt_d;
  logic [TCNT_W-1:0] tap_q, tap_d;
  logic signed [ACC_W-1:0] acc_q, acc_d;
  logic signed [WS_W-1:0]  ws_q, ws_d;
  logic              mac_v_q, mac_v_d;
  logic [SW-1:0]     pend_q, pend_d;
  logic              pend_valid_q, pend_valid_d;
  logic              pend_last_q, pend_last_d;
  logic              out_valid_q, out_valid_d;
  logic [SW-1:0]     out_sample_q, out_sample_d;
  logic              out_last_q, out_last_d;

  logic signed [SW-1:0] ring_mem [RING_DEPTH];
  logic signed [SW-1:0] wt_mem [MAX_PHASES*MAX_TAPS];
  logic [OFF_W-1:0]     off_mem [MAX_PHASES];
  logic [TCNT_W-1:0]    tot_mem [MAX_PHASES];
  logic signed [SW-1:0] ring_rd_q, wt_rd_q;
  logic signed [OFF_W-1:0] off_rd_q;
  logic [TCNT_W-1:0]    tot_rd_q;

  div_req_t div_req;
  div_rsp_t div_rsp;

  logic              in_acc, cfg_acc, out_free;
  logic [UP_W-1:0]   q_eff;
  logic [DOWN_W-1:0] p_eff;
  logic              pass;
  logic              flush;
  logic [TCNT_W-1:0] taps_eff;
  logic signed [JW-1:0] base, right, seen_s, j;
  logic              ready_out, due, inr, issue;
  logic signed [2*SW-1:0] prod;
  logic [ACC_W-1:0]  mag;
  logic [DIV_NW-1:0] qv;
  logic [SW-1:0]     res;
  logic [TSUM_W-1:0] tsum;
  logic [CW+UP_W-1:0] nq;
  logic              ring_we, wt_we, shape_we;
  logic              go_tap;
  logic              ws_pos;

  plr_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .rsp_o  (div_rsp)
  );

  always_comb begin
    in_acc    = sample_in.valid && sample_in.ready;
    cfg_acc   = cfg_wr.valid && cfg_wr.ready;
    out_free  = !out_valid_q || result_out.ready;
    q_eff     = (up_q == '0) ? UP_W'(1) :
                (up_q > UP_W'(MAX_PHASES)) ? UP_W'(MAX_PHASES) : up_q;
    p_eff     = (down_q == '0) ? DOWN_W'(1) : down_q;
    pass      = DOWN_W'(q_eff) == p_eff;
    flush     = func_q == FUNC_FLUSH;
    taps_eff  = (tot_rd_q > TCNT_W'(MAX_TAPS)) ? TCNT_W'(MAX_TAPS) : tot_rd_q;
    base      = $signed({2'b00, center_q}) + JW'(off_rd_q);
    right     = base + $signed({{(JW-TCNT_W){1'b0}}, taps_eff}) - JW'(1);
    seen_s    = $signed({2'b00, seen_q});
    ready_out = right < seen_s;
    due       = (cnt_q < TCNT_W'(MAX_OUT)) &&
                (flush ? ({{(DIV_NW-CW){1'b0}}, idx_q} < target_q) : ready_out);
    j         = base + $signed({{(JW-TCNT_W){1'b0}}, tap_q});
    inr       = !j[JW-1] && (j < seen_s);
    issue     = (state_q == S_TAP) && (tap_q != taps_eff);
    prod      = ring_rd_q * wt_rd_q;
    mag       = acc_q[ACC_W-1] ? ACC_W'(-acc_q) : ACC_W'(acc_q);
    qv        = div_rsp.quo;
    ws_pos    = !ws_q[WS_W-1] && (ws_q != '0);
    if (acc_q[ACC_W-1]) begin
      res = (qv > DIV_NW'(32768)) ? SW'(16'h8000) : SW'(~qv + 1'b1);
    end else begin
      res = (qv > DIV_NW'(32767)) ? SW'(16'h7fff) : SW'(qv);
    end
    tsum      = TSUM_W'(phase_q) + TSUM_W'(p_eff);
    nq        = seen_q * q_eff;
    ring_we   = (state_q == S_IDLE) && in_acc && (func_e'(sample_in.func) == FUNC_SAMPLE);
    wt_we     = (state_q == S_IDLE) && in_acc && (func_e'(sample_in.func) == FUNC_WEIGHT);
    shape_we  = (state_q == S_IDLE) && in_acc && (func_e'(sample_in.func) == FUNC_SHAPE);
    sample_in.ready = state_q == S_IDLE;
    cfg_wr.ready    = 1'b1;
  end

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: begin
        if (in_acc) begin
          case (func_e'(sample_in.func))
            FUNC_SAMPLE: state_d = pass ? S_EMIT : S_LOOK;
            FUNC_FLUSH:  state_d = pass ? S_IDLE : S_TGT;
            default:     state_d = S_IDLE;
          endcase
        end
      end
      S_TGT:   if (div_rsp.done) state_d = S_LOOK;
      S_LOOK:  state_d = S_CHECK;
      S_CHECK: begin
        if (pend_valid_q) state_d = S_EMIT;
        else if (due) state_d = S_TAP;
        else state_d = S_IDLE;
      end
      S_TAP:   if (tap_q == taps_eff) state_d = S_DRAIN;
      S_DRAIN: state_d = ws_pos ? S_DIVO : S_ADV;
      S_DIVO:  if (div_rsp.done) state_d = S_ADV;
      S_ADV:   state_d = S_ADVW;
      S_ADVW:  if (div_rsp.done) state_d = S_LOOK;
      S_EMIT:  if (out_free) state_d = pend_last_q ? S_IDLE : S_TAP;
      default: state_d = S_IDLE;
    endcase
  end

  // datapath and outputs
  always_comb begin
    up_d         = up_q;
    down_d       = down_q;
    func_d       = func_q;
    seen_d       = seen_q;
    idx_d        = idx_q;
    center_d     = center_q;
    phase_d      = phase_q;
    target_d     = target_q;
    cnt_d        = cnt_q;
    tap_d        = tap_q;
    acc_d        = acc_q;
    ws_d         = ws_q;
    mac_v_d      = issue && inr;
    pend_d       = pend_q;
    pend_valid_d = pend_valid_q;
    pend_last_d  = pend_last_q;
    out_valid_d  = out_valid_q && !result_out.ready;
    out_sample_d = out_sample_q;
    out_last_d   = out_last_q;
    go_tap       = 1'b0;
    div_req      = '0;

    if (cfg_acc) begin
      case (cfg_wr.index)
        CFG_UP:   up_d = cfg_wr.data[UP_W-1:0];
        CFG_DOWN: down_d = cfg_wr.data[DOWN_W-1:0];
        default:  ;
      endcase
    end

    if (mac_v_q) begin
      acc_d = acc_q + ACC_W'(prod);
      ws_d  = ws_q + WS_W'(wt_rd_q);
    end

    case (state_q)
      S_IDLE: begin
        if (in_acc) begin
          func_d = func_e'(sample_in.func);
          cnt_d  = '0;
          case (func_e'(sample_in.func))
            FUNC_SAMPLE: begin
              seen_d = seen_q + 1'b1;
              if (pass) begin
                pend_d       = sample_in.in_sample;
                pend_valid_d = 1'b1;
                pend_last_d  = 1'b1;
              end
            end
            FUNC_FLUSH: begin
              if (pass) begin
                seen_d   = '0;
                idx_d    = '0;
                center_d = '0;
                phase_d  = '0;
              end else begin
                div_req.start = 1'b1;
                div_req.num   = DIV_NW'({nq, 1'b0}) + DIV_NW'(p_eff);
                div_req.den   = DIV_DW'({p_eff, 1'b0});
                div_req.iters = DIV_IW'(DIV_NW);
              end
            end
            default: ;
          endcase
        end
      end
      S_TGT: if (div_rsp.done) target_d = div_rsp.quo;
      S_CHECK: begin
        pend_last_d = !due;
        if (!pend_valid_q && due) go_tap = 1'b1;
        if (!due && flush && !({{(DIV_NW-CW){1'b0}}, idx_q} < target_q)) begin
          seen_d   = '0;
          idx_d    = '0;
          center_d = '0;
          phase_d  = '0;
        end
      end
      S_TAP: if (issue) tap_d = tap_q + 1'b1;
      S_DRAIN: begin
        if (ws_pos) begin
          div_req.start = 1'b1;
          div_req.num   = DIV_NW'({mag, 1'b0}) + DIV_NW'(ws_q);
          div_req.den   = DIV_DW'({ws_q, 1'b0});
          div_req.iters = DIV_IW'(DIV_NW);
        end else begin
          pend_d       = '0;
          pend_valid_d = 1'b1;
          cnt_d        = cnt_q + 1'b1;
        end
      end
      S_DIVO: begin
        if (div_rsp.done) begin
          pend_d       = res;
          pend_valid_d = 1'b1;
          cnt_d        = cnt_q + 1'b1;
        end
      end
      S_ADV: begin
        div_req.start = 1'b1;
        div_req.num   = {tsum, {(DIV_NW-TSUM_W){1'b0}}};
        div_req.den   = DIV_DW'(q_eff);
        div_req.iters = DIV_IW'(TSUM_W);
      end
      S_ADVW: begin
        if (div_rsp.done) begin
          center_d = center_q + CW'(div_rsp.quo[TSUM_W-1:0]);
          phase_d  = div_rsp.rem[PH_W-1:0];
          idx_d    = idx_q + 1'b1;
        end
      end
      S_EMIT: begin
        if (out_free) begin
          out_valid_d  = 1'b1;
          out_sample_d = pend_q;
          out_last_d   = pend_last_q;
          pend_valid_d = 1'b0;
          if (!pend_last_q) go_tap = 1'b1;
        end
      end
      default: ;
    endcase

    if (go_tap) begin
      tap_d   = '0;
      acc_d   = '0;
      ws_d    = '0;
      mac_v_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      up_q         <= UP_W'(1);
      down_q       <= DOWN_W'(1);
      func_q       <= FUNC_SAMPLE;
      seen_q       <= '0;
      idx_q        <= '0;
      center_q     <= '0;
      phase_q      <= '0;
      cnt_q        <= '0;
      tap_q        <= '0;
      mac_v_q      <= 1'b0;
      pend_valid_q <= 1'b0;
      pend_last_q  <= 1'b0;
      out_valid_q  <= 1'b0;
    end else begin
      state_q      <= state_d;
      up_q         <= up_d;
      down_q       <= down_d;
      func_q       <= func_d;
      seen_q       <= seen_d;
      idx_q        <= idx_d;
      center_q     <= center_d;
      phase_q      <= phase_d;
      cnt_q        <= cnt_d;
      tap_q        <= tap_d;
      mac_v_q      <= mac_v_d;
      pend_valid_q <= pend_valid_d;
      pend_last_q  <= pend_last_d;
      out_valid_q  <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    target_q     <= target_d;
    acc_q        <= acc_d;
    ws_q         <= ws_d;
    pend_q       <= pend_d;
    out_sample_q <= out_sample_d;
    out_last_q   <= out_last_d;
  end

  // sample ring, weights and phase shapes
  always_ff @(posedge clk_i) begin
    if (ring_we) ring_mem[seen_q[RW-1:0]] <= sample_in.in_sample;
    ring_rd_q <= ring_mem[j[RW-1:0]];
  end

  always_ff @(posedge clk_i) begin
    if (wt_we) wt_mem[{sample_in.phase_sel, sample_in.tap_sel}] <= sample_in.weight_value;
    wt_rd_q <= wt_mem[{phase_q, tap_q[TAP_W-1:0]}];
  end

  always_ff @(posedge clk_i) begin
    if (shape_we) begin
      off_mem[sample_in.phase_sel] <= sample_in.left_offset;
      tot_mem[sample_in.phase_sel] <= sample_in.tap_total;
    end
    off_rd_q <= off_mem[phase_q];
    tot_rd_q <= tot_mem[phase_q];
  end

  assign result_out.valid       = out_valid_q;
  assign result_out.out_sample  = out_sample_q;
  assign result_out.last_of_run = out_last_q;

endmodule
`default_nettype wire

FILE: rtl/plr_div.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// plr_div
// Restoring divider, one quotient bit per cycle, numerator left aligned.
// ----------------------------------------------------------------------------
module plr_div
  import plr_pkg::*;
(
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  input  wire div_req_t req_i,
  output div_rsp_t      rsp_o
);

  logic              busy_q, busy_d;
  logic              done_q, done_d;
  logic [DIV_IW-1:0] cnt_q, cnt_d;
  logic [DIV_IW-1:0] iters_q, iters_d;
  logic [DIV_NW-1:0] num_q, num_d;
  logic [DIV_NW-1:0] quo_q, quo_d;
  logic [DIV_DW-1:0] den_q, den_d;
  logic [DIV_DW-1:0] rem_q, rem_d;
  logic [DIV_DW:0]   shifted;
  logic [DIV_DW:0]   diff;
  logic              ge;

  always_comb begin
    shifted = {rem_q, num_q[DIV_NW-1]};
    diff    = shifted - {1'b0, den_q};
    ge      = shifted >= {1'b0, den_q};
    busy_d  = busy_q;
    done_d  = 1'b0;
    cnt_d   = cnt_q;
    iters_d = iters_q;
    num_d   = num_q;
    quo_d   = quo_q;
    den_d   = den_q;
    rem_d   = rem_q;
    if (req_i.start) begin
      busy_d  = 1'b1;
      cnt_d   = '0;
      iters_d = req_i.iters;
      num_d   = req_i.num;
      den_d   = req_i.den;
      quo_d   = '0;
      rem_d   = '0;
    end else if (busy_q) begin
      num_d = {num_q[DIV_NW-2:0], 1'b0};
      quo_d = {quo_q[DIV_NW-2:0], ge};
      rem_d = ge ? diff[DIV_DW-1:0] : shifted[DIV_DW-1:0];
      cnt_d = cnt_q + 1'b1;
      if (cnt_q == iters_q - 1'b1) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    iters_q <= iters_d;
    num_q   <= num_d;
    quo_q   <= quo_d;
    den_q   <= den_d;
    rem_q   <= rem_d;
  end

  assign rsp_o.done = done_q;
  assign rsp_o.quo  = quo_q;
  assign rsp_o.rem  = rem_q;

endmodule
`default_nettype wire

FILE: rtl/plr_checker.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// plr_checker
// Port-level checks of the resampler, bound to the top level.
// ----------------------------------------------------------------------------
module plr_checker
  import plr_pkg::*;
(
  input wire logic        clk_i,
  input wire logic        rst_ni,
  input wire logic        in_valid_i,
  input wire logic        in_ready_i,
  input wire logic [1:0]  in_func_i,
  input wire logic        out_valid_i,
  input wire logic        out_ready_i,
  input wire logic [15:0] out_sample_i,
  input wire logic        out_last_i
);

  logic in_xfer;
  logic load_xfer;

  assign in_xfer   = in_valid_i && in_ready_i;
  assign load_xfer = in_xfer && (func_e'(in_func_i) == FUNC_WEIGHT ||
                                 func_e'(in_func_i) == FUNC_SHAPE);

  // stalled result holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(out_sample_i) &&
    $stable(out_last_i))
    else $error("result changed while stalled");

  // busy only after an input transfer
  a_busy_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $fell(in_ready_i) |-> $past(in_xfer))
    else $error("ready dropped without an input transfer");

  // loads finish at once
  a_load_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    load_xfer |=> in_ready_i)
    else $error("load left the block busy");

  // loads make no result
  a_load_quiet: assert property (@(posedge clk_i) disable iff (!rst_ni)
    load_xfer |=> !$rose(out_valid_i))
    else $error("load produced a result");

endmodule

bind polyphase_lanczos_resampler plr_checker u_plr_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .in_valid_i   (sample_in.valid),
  .in_ready_i   (sample_in.ready),
  .in_func_i    (sample_in.func),
  .out_valid_i  (result_out.valid),
  .out_ready_i  (result_out.ready),
  .out_sample_i (result_out.out_sample),
  .out_last_i   (result_out.last_of_run)
);
`default_nettype wire
